FILE: hw/rtl/dts_fd_pkg.sv
`timescale 1ns / 1ps

package dts_fd_pkg;

    // Width of the frame length fields.
    localparam int LEN_W = 15;

    // Sync word forms, also the code shown on sync_format.
    typedef enum logic [1:0] {
        FMT_RAW_BE = 2'd0,
        FMT_RAW_LE = 2'd1,
        FMT_14_BE  = 2'd2,
        FMT_14_LE  = 2'd3
    } fmt_t;

    // Sync bytes, first four header bytes of each form.
    localparam logic [7:0] SYNC_RAW_BE [4] = '{8'h7F, 8'hFE, 8'h80, 8'h01};
    localparam logic [7:0] SYNC_RAW_LE [4] = '{8'hFE, 8'h7F, 8'h01, 8'h80};
    localparam logic [7:0] SYNC_14_BE  [4] = '{8'h1F, 8'hFF, 8'hE8, 8'h00};
    localparam logic [7:0] SYNC_14_LE  [4] = '{8'hFF, 8'h1F, 8'h00, 8'hE8};

    // Reciprocal of 7 for floor(x / 7) with x below 2**18: (x * DIV7_MUL) >> DIV7_SHIFT.
    localparam int           DIV7_SHIFT = 20;
    localparam logic [17:0]  DIV7_MUL   = 18'd149797;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;
        logic check;
        logic decide;
        logic emit_load;
        logic emit_first;
        logic emit_last;
        logic pass_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_full;
        logic frame_ok;
        logic left_zero;
        logic left_le1;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/dts_fd_ctrl.sv
`timescale 1ns / 1ps

module dts_fd_ctrl #(
    parameter int HEADER_WINDOW = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dts_fd_pkg::status_t sts,
    output dts_fd_pkg::cmd_t    cmd
);

    localparam int CNT_W = $clog2(HEADER_WINDOW);

    typedef enum logic [2:0] {
        S_HUNT,
        S_CHECK,
        S_SIZE,
        S_EMIT,
        S_PASS
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    // State and header emit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state, commands and input stall.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_HUNT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.wr = 1'b1;
                    if (sts.window_full)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                cmd.decide = 1'b1;
                if (sts.frame_ok)
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_HUNT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load  = 1'b1;
                    cmd.emit_first = (cnt_reg == '0);
                    cmd.emit_last  = (cnt_reg == CNT_W'(HEADER_WINDOW - 1));
                    if (cmd.emit_last)
                    begin
                        state_next = sts.left_zero ? S_HUNT : S_PASS;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_PASS:
            begin
                in_stall = !sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    cmd.pass_load = 1'b1;
                    if (sts.left_le1)
                    begin
                        state_next = S_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

endmodule

FILE: hw/rtl/dts_fd_datapath.sv
`timescale 1ns / 1ps

module dts_fd_datapath #(
    parameter int HEADER_WINDOW = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    data_byte,
    input  dts_fd_pkg::cmd_t              cmd,
    output dts_fd_pkg::status_t           sts,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [7:0]                    out_byte,
    output logic                          frame_first,
    output logic                          frame_final,
    output logic [1:0]                    sync_format,
    output logic [dts_fd_pkg::LEN_W-1:0]  frame_bytes,
    output logic                          last_of_burst
);

    localparam int FILL_W = $clog2(HEADER_WINDOW + 1);
    localparam int LW     = dts_fd_pkg::LEN_W;

    logic [7:0]         win_reg [HEADER_WINDOW];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [LW-1:0]      left_reg;
    logic [LW-1:0]      left_next;
    dts_fd_pkg::fmt_t   fmt_reg;
    logic [LW-1:0]      len_reg;

    // Header check results.
    logic               hit;
    dts_fd_pkg::fmt_t   kind;
    logic               hit_reg;
    dts_fd_pkg::fmt_t   kind_reg;
    logic [15:0]        w2;
    logic [15:0]        w3;
    logic [15:0]        w4;
    logic [LW-1:0]      raw_size;
    logic [LW-1:0]      raw_size_reg;
    logic [LW-1:0]      n14;
    logic [17:0]        x8;
    logic [35:0]        prod;
    logic [LW-1:0]      q_reg;
    logic [LW-1:0]      q1;
    logic [LW-1:0]      size_sel;
    logic               drop;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         obyte_reg;
    logic               ofirst_reg;
    logic               ofinal_reg;
    dts_fd_pkg::fmt_t   ofmt_reg;
    logic [LW-1:0]      olen_reg;
    logic               olast_reg;
    logic               load;

    // Sync word match on the first four window bytes.
    always_comb
    begin
        hit  = 1'b1;
        kind = dts_fd_pkg::FMT_RAW_BE;
        if (win_reg[0] == dts_fd_pkg::SYNC_RAW_BE[0] && win_reg[1] == dts_fd_pkg::SYNC_RAW_BE[1]
            && win_reg[2] == dts_fd_pkg::SYNC_RAW_BE[2]
            && win_reg[3] == dts_fd_pkg::SYNC_RAW_BE[3])
        begin
            kind = dts_fd_pkg::FMT_RAW_BE;
        end
        else if (win_reg[0] == dts_fd_pkg::SYNC_RAW_LE[0]
            && win_reg[1] == dts_fd_pkg::SYNC_RAW_LE[1]
            && win_reg[2] == dts_fd_pkg::SYNC_RAW_LE[2]
            && win_reg[3] == dts_fd_pkg::SYNC_RAW_LE[3])
        begin
            kind = dts_fd_pkg::FMT_RAW_LE;
        end
        else if (win_reg[0] == dts_fd_pkg::SYNC_14_BE[0]
            && win_reg[1] == dts_fd_pkg::SYNC_14_BE[1]
            && win_reg[2] == dts_fd_pkg::SYNC_14_BE[2]
            && win_reg[3] == dts_fd_pkg::SYNC_14_BE[3])
        begin
            kind = dts_fd_pkg::FMT_14_BE;
        end
        else if (win_reg[0] == dts_fd_pkg::SYNC_14_LE[0]
            && win_reg[1] == dts_fd_pkg::SYNC_14_LE[1]
            && win_reg[2] == dts_fd_pkg::SYNC_14_LE[2]
            && win_reg[3] == dts_fd_pkg::SYNC_14_LE[3])
        begin
            kind = dts_fd_pkg::FMT_14_LE;
        end
        else
        begin
            hit = 1'b0;
        end
    end

    // Size fields; the byte order within each word follows the sync form.
    always_comb
    begin
        if (kind[0])
        begin
            w2 = {win_reg[5], win_reg[4]};
            w3 = {win_reg[7], win_reg[6]};
            w4 = {win_reg[9], win_reg[8]};
        end
        else
        begin
            w2 = {win_reg[4], win_reg[5]};
            w3 = {win_reg[6], win_reg[7]};
            w4 = {win_reg[8], win_reg[9]};
        end
        raw_size = {1'b0, w2[1:0], w3[15:4]} + LW'(1);
        n14      = {1'b0, w3[9:0], w4[13:10]} + LW'(1);
        x8       = {n14, 3'b000};
    end

    // 14-bit forms scale by 8/7: multiply by the reciprocal, registered below.
    assign prod = 36'(x8) * 36'(dts_fd_pkg::DIV7_MUL);

    // Round the scaled size up to even and pick the size of the matched form.
    assign q1       = q_reg + LW'(1);
    assign size_sel = kind_reg[1] ? {q1[LW-1:1], 1'b0} : raw_size_reg;

    assign sts.frame_ok    = hit_reg && (size_sel >= LW'(HEADER_WINDOW));
    assign sts.window_full = (fill_reg == FILL_W'(HEADER_WINDOW - 1));
    assign sts.left_zero   = (left_reg == '0);
    assign sts.left_le1    = (left_reg <= LW'(1));
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign drop = cmd.decide && !sts.frame_ok;
    assign load = cmd.emit_load || cmd.pass_load;

    // Fill count and bytes left in the frame.
    always_comb
    begin
        fill_next = fill_reg;
        left_next = left_reg;
        if (cmd.wr)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (drop)
        begin
            fill_next = FILL_W'(HEADER_WINDOW - 1);
        end
        else if (cmd.decide)
        begin
            fill_next = '0;
            left_next = size_sel - LW'(HEADER_WINDOW);
        end
        if (cmd.pass_load)
        begin
            left_next = sts.left_le1 ? '0 : left_reg - LW'(1);
        end
    end

    // The output word stays until taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Header window: write at the fill point, shift out the oldest byte.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HEADER_WINDOW; i++)
        begin
            if (cmd.wr && fill_reg == FILL_W'(i))
            begin
                win_reg[i] <= data_byte;
            end
            else if ((drop || cmd.emit_load) && i < HEADER_WINDOW - 1)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
        end
    end

    // Header check registers and frame parameters.
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            hit_reg      <= hit;
            kind_reg     <= kind;
            raw_size_reg <= raw_size;
            q_reg        <= prod[dts_fd_pkg::DIV7_SHIFT+LW-1:dts_fd_pkg::DIV7_SHIFT];
        end
        if (cmd.decide && sts.frame_ok)
        begin
            fmt_reg <= kind_reg;
            len_reg <= size_sel;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            obyte_reg  <= win_reg[0];
            ofirst_reg <= cmd.emit_first;
            ofinal_reg <= cmd.emit_last && sts.left_zero;
            ofmt_reg   <= fmt_reg;
            olen_reg   <= len_reg;
            olast_reg  <= cmd.emit_last;
        end
        else if (cmd.pass_load)
        begin
            obyte_reg  <= data_byte;
            ofirst_reg <= 1'b0;
            ofinal_reg <= sts.left_le1;
            ofmt_reg   <= fmt_reg;
            olen_reg   <= len_reg;
            olast_reg  <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = obyte_reg;
    assign frame_first   = ofirst_reg;
    assign frame_final   = ofinal_reg;
    assign sync_format   = ofmt_reg;
    assign frame_bytes   = olen_reg;
    assign last_of_burst = olast_reg;

endmodule

FILE: hw/rtl/dts_frame_deframer.sv
`timescale 1ns / 1ps

// Finds DTS core frames in a byte stream and passes them on byte by byte.
// Input channel: in_valid / in_stall with data_byte, one byte per word.
// Output channel: out_valid / out_stall with out_byte and its frame tags
// (frame_first, frame_final, sync_format, frame_bytes, last_of_burst).
// While hunting, a byte is taken every cycle while the window fills, and
// nothing comes out until the header window of HEADER_WINDOW bytes is full.
// A full window then goes through the sync match and the size check (the
// 8/7 scaling multiply is registered between them). With no sync, or a
// frame shorter than the window, the oldest byte is dropped and the window
// is full again with the next byte, so each further hunted byte is checked.
// On a frame, the window goes out one word per cycle while the receiver
// does not stall (HEADER_WINDOW words), during which input is stalled; the
// last of them carries last_of_burst. The rest of the frame flows through
// the output register, one byte per cycle while the receiver does not stall.
// When the receiver stalls, the output word holds; in pass-through the input
// is stalled in the same cycle, while hunting bytes are still taken.
// Reset empties the window, drops any frame in progress and clears out_valid.
module dts_frame_deframer #(
    parameter int HEADER_WINDOW = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    out_byte,
    output logic                          frame_first,
    output logic                          frame_final,
    output logic [1:0]                    sync_format,
    output logic [dts_fd_pkg::LEN_W-1:0]  frame_bytes,
    output logic                          last_of_burst
);

    dts_fd_pkg::cmd_t     cmd;
    dts_fd_pkg::status_t  sts;

    // Sequencing of hunt, header check, header emit and pass-through.
    dts_fd_ctrl #(
        .HEADER_WINDOW (HEADER_WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Window, size arithmetic and output register.
    dts_fd_datapath #(
        .HEADER_WINDOW (HEADER_WINDOW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .sts           (sts),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .frame_first   (frame_first),
        .frame_final   (frame_final),
        .sync_format   (sync_format),
        .frame_bytes   (frame_bytes),
        .last_of_burst (last_of_burst)
    );

endmodule

FILE: hw/rtl/dts_fd_checker.sv
`timescale 1ns / 1ps

module dts_fd_checker #(
    parameter int HEADER_WINDOW = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [7:0]                    out_byte,
    input  logic                          frame_first,
    input  logic                          frame_final,
    input  logic [1:0]                    sync_format,
    input  logic [dts_fd_pkg::LEN_W-1:0]  frame_bytes,
    input  logic                          last_of_burst
);

    // A stalled output word keeps its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte))
        else $error("stalled output word changed");

    // No frame is shorter than the header window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_bytes >= dts_fd_pkg::LEN_W'(HEADER_WINDOW))
        else $error("frame shorter than header window");

    // The first byte of a frame can never also be its last.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_first && frame_final))
        else $error("frame first and final on the same word");

    // A frame ends only on the last word of a burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_final |-> last_of_burst)
        else $error("frame ended inside a header burst");

    // Sizes of the 14-bit forms are rounded to even.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sync_format[1] |-> !frame_bytes[0])
        else $error("odd frame size for a 14-bit form");

endmodule

bind dts_frame_deframer dts_fd_checker #(
    .HEADER_WINDOW (HEADER_WINDOW)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .frame_first   (frame_first),
    .frame_final   (frame_final),
    .sync_format   (sync_format),
    .frame_bytes   (frame_bytes),
    .last_of_burst (last_of_burst)
);
